@@ rtl/bws_pkg.sv @@
// Shared types and constants for the 2D box window sum block.
// No dependencies; imported by box_window_sum_2d.
package bws_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // default capacity
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 16;

    // register values after reset
    localparam int RST_FRAME_ROWS  = 1024;
    localparam int RST_FRAME_COLS  = 1024;
    localparam int RST_WINDOW_SIZE = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS  = 2'd0,
        CFG_FRAME_COLS  = 2'd1,
        CFG_WINDOW_SIZE = 2'd2
    } t_cfg_idx;

    // position info carried down the pipeline with each word
    typedef struct packed {
        logic               c0;        // first column of a row
        logic               hsub;      // a column sum drops out of the window
        logic               emit;      // a full window ends here
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic               last_win;
    } t_tag;

endpackage

@@ rtl/box_window_sum_2d.sv @@
// 2D box window sum: sum of every full KxK window of a raster-order frame.
// Throughput: one word per cycle unless the output stalls; each word passes stage 1, stage 2, the output register.
// Rate is set by the column-sum RAM read-modify-write loop (forwarded when adjacent).
// Reset (sync, active low): frame 1024x1024, window 3, position at row 0 col 0.
// A register write also restarts the frame position.
module box_window_sum_2d #(
    parameter int MAX_HEIGHT = bws_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = bws_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = bws_pkg::DEF_MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bws_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bws_pkg::CFG_W-1:0]           i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [bws_pkg::SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bws_pkg::SUM_W-1:0]    o_window_sum,
    output logic [bws_pkg::COORD_W-1:0]         o_top_row,
    output logic [bws_pkg::COORD_W-1:0]         o_left_col,
    output logic                                o_last_window
);

    import bws_pkg::*;

    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW  = $clog2(MAX_WINDOW + 1);
    localparam int RRW = $clog2(MAX_HEIGHT + 1);
    localparam int CCW = $clog2(MAX_WIDTH + 1);
    localparam int XA  = (RRW > CCW) ? RRW : CCW;
    localparam int XW  = ((XA > KW) ? XA : KW) + 1;
    localparam int OW  = KW + 1;
    localparam int CSW = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int LAW = SW + CW;

    // configuration, held clamped
    logic [RRW-1:0] r_rows;
    logic [CCW-1:0] r_cols;
    logic [KW-1:0]  r_k;

    // raster position of the next word
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [SW-1:0] r_slot;      // row mod MAX_WINDOW

    logic adv;
    logic in_acc;

    // stage 0 decode
    logic [XW-1:0] row_x, col_x, k_x, rows_x, cols_x;
    logic          col_last, row_last;
    logic [OW-1:0] old_w;
    logic [SW-1:0] old_slot;
    logic          vsub0;
    t_tag          tag0;

    // stage 1
    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic [CW-1:0]              r_s1_col;
    logic                       r_s1_r0;
    logic                       r_s1_vsub;
    logic                       r_s1_fwd;
    logic signed [CSW-1:0]      r_s1_fwd_cs;
    t_tag                       r_s1_tag;
    logic [CSW-1:0]             colsum_rd;
    logic [SAMPLE_W-1:0]        line_rd;
    logic signed [CSW-1:0]      cs_prev;
    logic signed [CSW-1:0]      cs1;

    // stage 2
    logic                       r_s2_valid;
    logic signed [CSW-1:0]      r_s2_cs;
    t_tag                       r_s2_tag;
    logic signed [SUM_W-1:0]    r_run;
    logic signed [CSW-1:0]      r_hist [MAX_WINDOW];
    logic [SW-1:0]              hidx;
    logic signed [SUM_W-1:0]    run_sum;

    // output register
    logic                       r_out_valid;
    logic signed [SUM_W-1:0]    r_out_sum;
    logic [COORD_W-1:0]         r_out_top;
    logic [COORD_W-1:0]         r_out_left;
    logic                       r_out_last;

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;

    // ---------------------------------------------------------------- stage 0
    always_comb begin
        row_x    = XW'(r_row);
        col_x    = XW'(r_col);
        k_x      = XW'(r_k);
        rows_x   = XW'(r_rows);
        cols_x   = XW'(r_cols);
        col_last = (col_x + XW'(1)) == cols_x;
        row_last = (row_x + XW'(1)) == rows_x;
        vsub0    = row_x >= k_x;

        // line-store slot of the row that leaves the window
        old_w    = OW'(r_slot) + ((OW'(r_slot) >= OW'(r_k)) ? OW'(0) : OW'(MAX_WINDOW))
                   - OW'(r_k);
        old_slot = old_w[SW-1:0];

        tag0.c0       = (r_col == '0);
        tag0.hsub     = col_x >= k_x;
        tag0.emit     = (k_x <= rows_x) && (k_x <= cols_x)
                        && (row_x + XW'(1) >= k_x) && (col_x + XW'(1) >= k_x);
        tag0.top      = COORD_W'(row_x + XW'(1) - k_x);
        tag0.left     = COORD_W'(col_x + XW'(1) - k_x);
        tag0.last_win = row_last && col_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RRW'(RST_FRAME_ROWS  > MAX_HEIGHT ? MAX_HEIGHT : RST_FRAME_ROWS);
            r_cols <= CCW'(RST_FRAME_COLS  > MAX_WIDTH  ? MAX_WIDTH  : RST_FRAME_COLS);
            r_k    <= KW'(RST_WINDOW_SIZE > MAX_WINDOW ? MAX_WINDOW : RST_WINDOW_SIZE);
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_ROWS: begin
                    if (i_cfg_wdata == '0) begin
                        r_rows <= RRW'(1);
                    end else if (i_cfg_wdata > MAX_HEIGHT) begin
                        r_rows <= RRW'(MAX_HEIGHT);
                    end else begin
                        r_rows <= RRW'(i_cfg_wdata);
                    end
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                end
                CFG_FRAME_COLS: begin
                    if (i_cfg_wdata == '0) begin
                        r_cols <= CCW'(1);
                    end else if (i_cfg_wdata > MAX_WIDTH) begin
                        r_cols <= CCW'(MAX_WIDTH);
                    end else begin
                        r_cols <= CCW'(i_cfg_wdata);
                    end
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                end
                CFG_WINDOW_SIZE: begin
                    if (i_cfg_wdata[4:0] == '0) begin
                        r_k <= KW'(1);
                    end else if (i_cfg_wdata[4:0] > MAX_WINDOW) begin
                        r_k <= KW'(MAX_WINDOW);
                    end else begin
                        r_k <= KW'(i_cfg_wdata[4:0]);
                    end
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + RW'(1);
                    r_slot <= (r_slot == SW'(MAX_WINDOW - 1)) ? '0 : r_slot + SW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line store: written on accept, read of the leaving row issued alongside
    bws_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (1 << LAW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr ({r_slot, r_col}),
        .i_wdata (i_sample),
        .i_re    (in_acc),
        .i_raddr ({old_slot, r_col}),
        .o_rdata (line_rd)
    );

    // column sums: read on accept, written back from stage 1
    bws_ram #(
        .WIDTH (CSW),
        .DEPTH (MAX_WIDTH)
    ) u_colsum_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (cs1),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (colsum_rd)
    );

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        cs_prev = r_s1_fwd ? r_s1_fwd_cs : $signed(colsum_rd);
        if (r_s1_r0) begin
            cs1 = CSW'(r_s1_sample);
        end else begin
            cs1 = cs_prev + CSW'(r_s1_sample)
                  - (r_s1_vsub ? CSW'($signed(line_rd)) : CSW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_sample;
            r_s1_col    <= r_col;
            r_s1_r0     <= (r_row == '0);
            r_s1_vsub   <= vsub0;
            r_s1_tag    <= tag0;
            // write-back of the word ahead lands at this edge, too late for the read
            r_s1_fwd    <= r_s1_valid && (r_s1_col == r_col);
            r_s1_fwd_cs <= cs1;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb begin
        hidx    = SW'(r_k - KW'(1));
        run_sum = (r_s2_tag.c0 ? SUM_W'(0) : r_run) + SUM_W'(r_s2_cs)
                  - (r_s2_tag.hsub ? SUM_W'(r_hist[hidx]) : SUM_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_cs  <= cs1;
            r_s2_tag <= r_s1_tag;
        end
        if (adv && r_s2_valid) begin
            r_run     <= run_sum;
            r_hist[0] <= r_s2_cs;
            for (int i = 1; i < MAX_WINDOW; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_tag.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sum  <= run_sum;
            r_out_top  <= r_s2_tag.top;
            r_out_left <= r_s2_tag.left;
            r_out_last <= r_s2_tag.last_win;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_sum  = r_out_sum;
    assign o_top_row     = r_out_top;
    assign o_left_col    = r_out_left;
    assign o_last_window = r_out_last;

endmodule

@@ rtl/bws_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first: a read of the address being written returns the old contents.
// No dependencies.
module bws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
